FILE: sv/xrg_pkg.sv
// Shared types and constants for the xoshiro256** generator with splitmix64 seeding.
// No dependencies; imported by xoshiro_random_generator.
`default_nettype none

package xrg_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned CMD_W  = 2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CMD_W-1:0]  t_cmd;

    localparam t_cmd CMD_RESEED  = 2'd0;
    localparam t_cmd CMD_RAW     = 2'd1;
    localparam t_cmd CMD_UNIT    = 2'd2;
    localparam t_cmd CMD_BOUNDED = 2'd3;

    localparam t_word GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam t_word MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam t_word MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    localparam logic [1:0] MUL_LAST  = 2'd3;
    localparam logic [1:0] WORD_LAST = 2'd3;
    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam int unsigned UNIT_SHIFT = 11;

endpackage

`default_nettype wire

FILE: sv/xoshiro_random_generator.sv
// Top level of the xoshiro256** generator: command sequencer, shared 32x32 multiplier,
// serial restoring divider and output register. Depends on xrg_pkg.
//
// Usage:
//   Input channel (i_valid/o_ready) carries a command with low and high bounds.
//   Output channel (o_valid/i_ready) returns one value/error pair per command.
//   Config channel (i_cfg_valid/o_cfg_ready) writes the seed; write it while idle.
// Work per command, from transfer to result in the output register:
//   reseed: four splitmix64 steps, each with two multiplies
//   through the shared 32x32 multiplier.
//   raw word / unit fraction: one generator step in two adds.
//   bounded: two serial modulo passes, one for the rejection threshold and one
//   for the reduction, plus another generator step for every rejected word.
//   Empty bounds return an error.
//   One command is in flight at a time; o_ready is high only when the sequencer
//   is idle.
// Reset: the seed clears and the state is expanded from seed zero;
//   o_ready stays low meanwhile.
// Stall: a finished result waits in the output register; the next command can be
//   taken meanwhile, and its result is held until the register frees up.
`default_nettype none

module xoshiro_random_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [xrg_pkg::CMD_W-1:0]   i_command,
    input  logic signed [xrg_pkg::WORD_W-1:0] i_low_bound,
    input  logic signed [xrg_pkg::WORD_W-1:0] i_high_bound,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [xrg_pkg::WORD_W-1:0]  o_value,
    output logic                        o_error,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [xrg_pkg::WORD_W-1:0]  i_seed_value
);
    import xrg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_ADD,
        S_MIX_X1,
        S_MUL,
        S_MIX_X2,
        S_MIX_OUT,
        S_GEN1,
        S_GEN2,
        S_CHECK,
        S_DIV,
        S_REJECT,
        S_BOUND_ADD,
        S_DONE
    } t_state;

    t_state             r_state;
    logic               r_init;
    t_cmd               r_cmd;
    logic signed [63:0] r_lo;
    logic signed [63:0] r_hi;
    t_word              r_seed;
    t_word              r_words [4];
    t_word              r_ctr;
    logic [1:0]         r_word_idx;
    t_word              r_mul_a;
    logic               r_mul_sel;
    logic [1:0]         r_mstep;
    logic [63:0]        r_prod;
    t_word              r_acc;
    t_word              r_t;
    t_word              r_range;
    t_word              r_thr;
    t_word              r_dividend;
    t_word              r_rem;
    logic [5:0]         r_cnt;
    logic               r_div_thr;
    t_word              r_res;
    logic               r_err;
    logic               r_out_valid;
    t_word              r_out_value;
    logic               r_out_error;

    t_word       w_mul_b;
    logic [31:0] m_x;
    logic [31:0] m_y;
    logic [63:0] w_prod;
    t_word       w_mix_z;
    t_word       w_shl17;
    t_word       w_n0;
    t_word       w_n1;
    t_word       w_n2;
    t_word       w_n3;
    t_word       w_rot7;
    t_word       w_gen_out;
    logic [64:0] w_rem_shift;
    logic [65:0] w_rem_diff;
    t_word       w_rem_next;
    logic        w_bad_bounds;

    assign w_mul_b = r_mul_sel ? MIX_MUL_B : MIX_MUL_A;

    always_comb begin
        m_x = r_mul_a[31:0];
        m_y = w_mul_b[31:0];
        case (r_mstep)
            2'd1:    m_x = r_mul_a[63:32];
            2'd2:    m_y = w_mul_b[63:32];
            default: ;
        endcase
    end

    assign w_prod  = m_x * m_y;
    assign w_mix_z = r_acc ^ (r_acc >> 31);

    assign w_shl17   = r_words[1] << 17;
    assign w_n2      = r_words[2] ^ r_words[0];
    assign w_n3      = r_words[3] ^ r_words[1];
    assign w_n1      = r_words[1] ^ w_n2;
    assign w_n0      = r_words[0] ^ w_n3;
    assign w_rot7    = {r_t[56:0], r_t[63:57]};
    assign w_gen_out = w_rot7 + (w_rot7 << 3);

    assign w_rem_shift = {r_rem, r_dividend[63]};
    assign w_rem_diff  = {1'b0, w_rem_shift} - {2'b00, r_range};
    assign w_rem_next  = w_rem_diff[65] ? w_rem_shift[63:0] : w_rem_diff[63:0];

    assign w_bad_bounds = (r_hi <= r_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_seed_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_MIX_ADD;
            r_init      <= 1'b1;
            r_ctr       <= '0;
            r_word_idx  <= '0;
            r_mstep     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_res       <= '0;
            r_err       <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_DONE || r_init)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_command;
                        r_lo  <= i_low_bound;
                        r_hi  <= i_high_bound;
                        r_res <= '0;
                        r_err <= 1'b0;
                        unique case (i_command)
                            CMD_RESEED: begin
                                r_ctr      <= r_seed;
                                r_word_idx <= '0;
                                r_state    <= S_MIX_ADD;
                            end
                            CMD_RAW, CMD_UNIT: r_state <= S_GEN1;
                            default:           r_state <= S_CHECK;
                        endcase
                    end
                end
                S_MIX_ADD: begin
                    r_ctr   <= r_ctr + GOLDEN_GAMMA;
                    r_state <= S_MIX_X1;
                end
                S_MIX_X1: begin
                    r_mul_a   <= r_ctr ^ (r_ctr >> 30);
                    r_mul_sel <= 1'b0;
                    r_mstep   <= '0;
                    r_state   <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == 2'd1) begin
                        r_acc <= r_prod;
                    end else if (r_mstep != 2'd0) begin
                        r_acc <= r_acc + {r_prod[31:0], 32'b0};
                    end
                    if (r_mstep == MUL_LAST) begin
                        r_state <= r_mul_sel ? S_MIX_OUT : S_MIX_X2;
                    end
                end
                S_MIX_X2: begin
                    r_mul_a   <= r_acc ^ (r_acc >> 27);
                    r_mul_sel <= 1'b1;
                    r_mstep   <= '0;
                    r_state   <= S_MUL;
                end
                S_MIX_OUT: begin
                    r_words[r_word_idx] <= w_mix_z;
                    r_word_idx          <= r_word_idx + 2'd1;
                    r_state <= (r_word_idx == WORD_LAST) ? S_DONE : S_MIX_ADD;
                end
                S_GEN1: begin
                    r_t        <= r_words[1] + (r_words[1] << 2);
                    r_words[0] <= w_n0;
                    r_words[1] <= w_n1;
                    r_words[2] <= w_n2 ^ w_shl17;
                    r_words[3] <= {w_n3[18:0], w_n3[63:19]};
                    r_state    <= S_GEN2;
                end
                S_GEN2: begin
                    r_dividend <= w_gen_out;
                    r_res      <= (r_cmd == CMD_UNIT) ? (w_gen_out >> UNIT_SHIFT) : w_gen_out;
                    r_state    <= (r_cmd == CMD_BOUNDED) ? S_REJECT : S_DONE;
                end
                S_CHECK: begin
                    if (w_bad_bounds) begin
                        r_err   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_range    <= $unsigned(r_hi - r_lo);
                        r_dividend <= $unsigned(r_lo - r_hi);
                        r_rem      <= '0;
                        r_cnt      <= '0;
                        r_div_thr  <= 1'b1;
                        r_state    <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem      <= w_rem_next;
                    r_dividend <= r_dividend << 1;
                    r_cnt      <= r_cnt + 6'd1;
                    if (r_cnt == DIV_LAST) begin
                        if (r_div_thr) begin
                            r_thr   <= w_rem_next;
                            r_state <= S_GEN1;
                        end else begin
                            r_state <= S_BOUND_ADD;
                        end
                    end
                end
                S_REJECT: begin
                    if (r_dividend < r_thr) begin
                        r_state <= S_GEN1;
                    end else begin
                        r_rem     <= '0;
                        r_cnt     <= '0;
                        r_div_thr <= 1'b0;
                        r_state   <= S_DIV;
                    end
                end
                S_BOUND_ADD: begin
                    r_res   <= $unsigned(r_lo) + r_rem;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_init) begin
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res;
                        r_out_error <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_error     = r_out_error;
    assign o_cfg_ready = 1'b1;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sequencer still ready after taking a command");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_value == '0))
        else $error("error result carries a nonzero value");

    a_mstep_only_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MUL) |-> (r_mstep == 2'd0))
        else $error("multiply step counter left running");

    a_rem_below_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_range))
        else $error("partial remainder not below range");

    a_no_output_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (!o_valid && !o_ready))
        else $error("activity during seed expansion after reset");

endmodule

`default_nettype wire

FILE: test/tb_xoshiro_random_generator.sv
// Self-checking testbench for xoshiro_random_generator: directed and random commands
// with seed changes, checked against an in-bench xoshiro256** / splitmix64 predictor.
// Depends on xrg_pkg and the xoshiro_random_generator RTL.

module tb_xoshiro_random_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import xrg_pkg::*;

    localparam t_word       SM_GAMMA       = 64'h9E37_79B9_7F4A_7C15;
    localparam t_word       SM_MUL_A       = 64'hBF58_476D_1CE4_E5B9;
    localparam t_word       SM_MUL_B       = 64'h94D0_49BB_1331_11EB;
    localparam int unsigned FRACTION_SHIFT = 11;
    localparam t_word       S_MIN          = 64'h8000_0000_0000_0000;
    localparam t_word       S_MAX          = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam t_word       ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int unsigned CYCLE_LIMIT    = 2_000_000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned LONG_HOLD      = 600;

    typedef struct {
        t_cmd  cmd;
        t_word value;
        logic  error;
    } t_draw;

    class draw_board;
        t_word seed_reg;
        t_word gen_words [4];
        t_draw expected_draws [$];
        int    failures;

        function new();
            seed_reg = '0;
            failures = 0;
            expand_seed(seed_reg);
        endfunction

        function void set_seed(t_word seed);
            seed_reg = seed;
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        function t_word splitmix_next(inout t_word ctr);
            t_word z;
            ctr = ctr + SM_GAMMA;
            z = ctr;
            z = (z ^ (z >> 30)) * SM_MUL_A;
            z = (z ^ (z >> 27)) * SM_MUL_B;
            return z ^ (z >> 31);
        endfunction

        function void expand_seed(t_word seed);
            t_word ctr;
            ctr = seed;
            for (int k = 0; k < 4; k++) begin
                gen_words[k] = splitmix_next(ctr);
            end
        endfunction

        function t_word rotl(t_word x, int unsigned k);
            return (x << k) | (x >> (64 - k));
        endfunction

        function t_word step_generator();
            t_word out_word;
            t_word carry;
            out_word = rotl(gen_words[1] * 64'd5, 7) * 64'd9;
            carry = gen_words[1] << 17;
            gen_words[2] ^= gen_words[0];
            gen_words[3] ^= gen_words[1];
            gen_words[1] ^= gen_words[2];
            gen_words[0] ^= gen_words[3];
            gen_words[2] ^= carry;
            gen_words[3] = rotl(gen_words[3], 45);
            return out_word;
        endfunction

        function void note_command(t_cmd cmd, t_word lo, t_word hi);
            t_draw d;
            t_word span;
            t_word floor_reject;
            t_word x;
            d.cmd   = cmd;
            d.value = '0;
            d.error = 1'b0;
            case (cmd)
                CMD_RESEED: begin
                    expand_seed(seed_reg);
                end
                CMD_RAW: begin
                    d.value = step_generator();
                end
                CMD_UNIT: begin
                    d.value = step_generator() >> FRACTION_SHIFT;
                end
                default: begin
                    if ($signed(hi) <= $signed(lo)) begin
                        d.error = 1'b1;
                    end else begin
                        span = hi - lo;
                        floor_reject = (64'd0 - span) % span;
                        do x = step_generator(); while (x < floor_reject);
                        d.value = lo + x % span;
                    end
                end
            endcase
            expected_draws.push_back(d);
        endfunction

        function void check_draw(t_word value, logic error);
            t_draw d;
            if (expected_draws.size() == 0) begin
                failures++;
                $display("%0t: result with nothing expected: value %h error %b",
                         $time, value, error);
                return;
            end
            d = expected_draws.pop_front();
            if (value !== d.value) begin
                failures++;
                $display("%0t: value mismatch (cmd %0d): expected %h actual %h",
                         $time, d.cmd, d.value, value);
            end
            if (error !== d.error) begin
                failures++;
                $display("%0t: error mismatch (cmd %0d): expected %b actual %b",
                         $time, d.cmd, d.error, error);
            end
        endfunction
    endclass

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  i_valid      = 1'b0;
    t_cmd  i_command    = CMD_RESEED;
    t_word i_low_bound  = '0;
    t_word i_high_bound = '0;
    logic  i_ready      = 1'b0;
    logic  i_cfg_valid  = 1'b0;
    t_word i_seed_value = '0;
    logic  o_ready;
    logic  o_valid;
    t_word o_value;
    logic  o_error;
    logic  o_cfg_ready;

    draw_board   board;
    int unsigned cycle_count     = 0;
    int unsigned hold_off_cycles = 0;
    bit          calm            = 1'b0;

    xoshiro_random_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_low_bound  (i_low_bound),
        .i_high_bound (i_high_bound),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_error      (o_error),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_seed_value (i_seed_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_draw(o_value, o_error);
        end
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
                i_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_command(input t_cmd cmd, input t_word lo, input t_word hi);
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_low_bound  <= lo;
        i_high_bound <= hi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_command(cmd, lo, hi);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input t_word seed);
        i_cfg_valid  <= 1'b1;
        i_seed_value <= seed;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_seed(seed);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void random_command(output t_cmd cmd, output t_word lo,
                                           output t_word hi);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        lo   = rand_word();
        hi   = rand_word();
        if (pick < 8) begin
            cmd = CMD_RESEED;
        end else if (pick < 38) begin
            cmd = CMD_RAW;
        end else if (pick < 63) begin
            cmd = CMD_UNIT;
        end else begin
            cmd = CMD_BOUNDED;
            case ($urandom_range(0, 9))
                0, 1, 2: hi = lo + 64'($urandom_range(1, 1000));
                3, 4: ;
                5: begin
                    lo = S_MIN + 64'($urandom_range(0, 255));
                    hi = S_MAX - 64'($urandom_range(0, 255));
                end
                6: begin
                    lo = S_MIN + 64'($urandom_range(0, 255));
                    hi = lo + S_MIN + 64'($urandom_range(1, 4096));
                end
                7: hi = lo;
                8: hi = lo + (64'd1 << $urandom_range(0, 62));
                default: begin
                    lo = 64'd0 - 64'($urandom_range(0, 100));
                    hi = 64'($urandom_range(0, 100));
                end
            endcase
        end
    endfunction

    task automatic run_phase(input t_word seed, input int count, input int hold_at,
                             input int pause_at);
        t_cmd  cmd;
        t_word lo;
        t_word hi;
        drain_results();
        write_seed(seed);
        send_command(CMD_RESEED, rand_word(), rand_word());
        for (int n = 1; n < count; n++) begin
            if (n == hold_at) begin
                hold_off_cycles = LONG_HOLD;
            end
            if (n == pause_at) begin
                drain_results();
            end
            random_command(cmd, lo, hi);
            send_command(cmd, lo, hi);
        end
    endtask

    initial begin : stimulus
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // state straight out of reset
        send_command(CMD_RAW, '0, '0);
        send_command(CMD_UNIT, S_MAX, S_MIN);
        send_command(CMD_BOUNDED, S_MIN, S_MAX);

        drain_results();
        write_seed(ALL_ONES);
        send_command(CMD_RESEED, ALL_ONES, ALL_ONES);
        send_command(CMD_RAW, ALL_ONES, '0);
        send_command(CMD_UNIT, '0, ALL_ONES);
        send_command(CMD_BOUNDED, ALL_ONES, '0);
        send_command(CMD_BOUNDED, 64'd5, 64'd5);
        send_command(CMD_BOUNDED, S_MAX, S_MIN);
        send_command(CMD_BOUNDED, S_MIN, S_MIN + 64'd1);
        send_command(CMD_BOUNDED, S_MIN, 64'd1);
        send_command(CMD_BOUNDED, 64'd0, 64'd3);
        send_command(CMD_BOUNDED, S_MIN, 64'd0);
        send_command(CMD_BOUNDED, S_MAX - 64'd1, S_MAX);
        send_command(CMD_BOUNDED, S_MIN, S_MAX);
        send_command(CMD_BOUNDED, 64'd0, 64'd1);

        drain_results();
        write_seed('0);
        send_command(CMD_RESEED, '0, '0);
        send_command(CMD_RAW, S_MIN, S_MIN);
        send_command(CMD_UNIT, ALL_ONES, ALL_ONES);
        send_command(CMD_BOUNDED, 64'd0 - 64'd10, 64'd10);
        send_command(CMD_BOUNDED, 64'd1, 64'd0);

        run_phase('0, 240, 60, -1);
        run_phase(ALL_ONES, 240, -1, 120);
        run_phase(rand_word(), 240, -1, -1);
        run_phase(64'd1, 240, 30, 200);
        run_phase(S_MIN, 220, -1, -1);
        calm = 1'b1;
        run_phase(rand_word(), 220, -1, -1);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
